[rtl/core/mcsr_pkg.sv]
// Shared types, codes and helper functions of the min-churn slot rebalancer.
package mcsr_pkg;

  localparam int SLOTS_DEF   = 4096;
  localparam int MEMBERS_DEF = 64;

  localparam logic [18:0] SUM_MAX = 19'h7FFFF;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_TARGET = 3'd1,
    CMD_OWNER  = 3'd2,
    CMD_RUN    = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_ZERO     = 3'd1;
  localparam logic [2:0] STS_DUP      = 3'd2;
  localparam logic [2:0] STS_INCONS   = 3'd3;
  localparam logic [2:0] STS_MOVES    = 3'd4;
  localparam logic [2:0] STS_INTERNAL = 3'd5;
  localparam logic [2:0] STS_FULL     = 3'd6;
  localparam logic [2:0] STS_NOTREADY = 3'd7;

  localparam logic [1:0] CFG_SLOT_TOTAL = 2'd0;
  localparam logic [1:0] CFG_MOVE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_REUSE      = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] member_id;
    logic [12:0] target_count;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot_index;
    logic [15:0] new_owner;
    logic [15:0] old_owner;
    logic        moved;
    logic [12:0] churn;
    logic [12:0] kept_slots;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [12:0] tgt;
    logic        is_tgt;
    logic [12:0] rem;
    logic [12:0] pend;
  } row_t;

  // Loss of keepable slots when one pending old slot of a member goes away.
  function automatic logic drop_pending(input logic [12:0] p, input logic [12:0] r);
    drop_pending = (p != 13'd0) && (p <= r);
  endfunction

  // Loss of keepable slots when one remaining slot of a member is used up.
  function automatic logic drop_remaining(input logic [12:0] p, input logic [12:0] r);
    drop_remaining = (r != 13'd0) && (r <= p);
  endfunction

endpackage

[rtl/core/mcsr_out_stage.sv]
// Output register that holds one response until the consumer takes it.
module mcsr_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mcsr_pkg::out_rsp_t push_data,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output mcsr_pkg::out_rsp_t out_data
);
  import mcsr_pkg::*;

  logic     valid_r;
  out_rsp_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

[rtl/core/min_churn_slot_rebalancer_core.sv]
// Top level of the min-churn slot rebalancer: sequencer around the row and slot memories.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall  | in_data   (command, member_id, target_count)
//   out_    | response  | out_valid/out_stall| out_data  (status, slot, owners, counts)
//   cfg_    | write     | cfg_we             | cfg_index, cfg_data
//
// A target load walks the table rows for the sort search and shift. In a run every
// slot scans the row memory through its single read port. Reset is synchronous and
// leaves the tables empty.
// in_stall is high while a request is in work; a stalled output holds its response.
module min_churn_slot_rebalancer_core #(
  parameter int SLOTS   = mcsr_pkg::SLOTS_DEF,
  parameter int MEMBERS = mcsr_pkg::MEMBERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcsr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcsr_pkg::out_rsp_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import mcsr_pkg::*;

  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW = $clog2(SLOTS + 1);
  localparam int MIW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  localparam int MCW = $clog2(MEMBERS + 1);

  typedef struct packed {
    logic [15:0]    old;
    logic [MIW-1:0] nidx;
  } slot_t;

  typedef enum logic [34:0] {
    S_IDLE     = 35'd1 << 0,
    S_RESP     = 35'd1 << 1,
    S_STR_RD   = 35'd1 << 2,
    S_STR_EX   = 35'd1 << 3,
    S_FND_RD   = 35'd1 << 4,
    S_FND_EX   = 35'd1 << 5,
    S_INS_RD   = 35'd1 << 6,
    S_INS_EX   = 35'd1 << 7,
    S_TL_STRIP = 35'd1 << 8,
    S_TL_FOUND = 35'd1 << 9,
    S_RUN_CHK  = 35'd1 << 10,
    S_DON_RD   = 35'd1 << 11,
    S_DON_EX   = 35'd1 << 12,
    S_DON_POST = 35'd1 << 13,
    S_RUN_CNT  = 35'd1 << 14,
    S_INIT_RD  = 35'd1 << 15,
    S_INIT_EX  = 35'd1 << 16,
    S_PEND_RD  = 35'd1 << 17,
    S_PEND_EX  = 35'd1 << 18,
    S_PEND_ADD = 35'd1 << 19,
    S_PEND_WR  = 35'd1 << 20,
    S_BUD_RD   = 35'd1 << 21,
    S_BUD_EX   = 35'd1 << 22,
    S_SL_RD    = 35'd1 << 23,
    S_SL_EX    = 35'd1 << 24,
    S_OI_RD    = 35'd1 << 25,
    S_OI_EX    = 35'd1 << 26,
    S_SC_RD    = 35'd1 << 27,
    S_SC_EX    = 35'd1 << 28,
    S_FIN      = 35'd1 << 29,
    S_FC_RD    = 35'd1 << 30,
    S_FC_EX    = 35'd1 << 31,
    S_RO_RD    = 35'd1 << 32,
    S_RO_EX    = 35'd1 << 33,
    S_RO_EX2   = 35'd1 << 34
  } state_t;

  // Memories.
  row_t  mmem [MEMBERS];
  slot_t smem [SLOTS];
  row_t  mm_rdata, mm_wdata;
  slot_t sm_rdata, sm_wdata;
  logic  mm_we, sm_we;
  logic [MIW-1:0] mm_raddr, mm_waddr;
  logic [SAW-1:0] sm_raddr, sm_waddr;

  always_ff @(posedge clk) begin
    if (mm_we) begin
      mmem[mm_waddr] <= mm_wdata;
    end
    mm_rdata <= mmem[mm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[sm_waddr] <= sm_wdata;
    end
    sm_rdata <= smem[sm_raddr];
  end

  // Control registers.
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [MCW-1:0] i_r, i_nxt, n_r, n_nxt, pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic [SCW-1:0] s_r, s_nxt, olo_r, olo_nxt;
  logic [SAW-1:0] rptr_r, rptr_nxt;
  logic [18:0] tsum_r, tsum_nxt;
  logic [12:0] budget_r, budget_nxt, ach_r, ach_nxt, kept_r, kept_nxt, move_r, move_nxt;
  logic [12:0] slot_total_r, slot_total_nxt, limit_r, limit_nxt;
  logic [2:0]  rstat_r, rstat_nxt;
  logic hit_r, hit_nxt, donors_r, donors_nxt, reused_r, reused_nxt, reuse_r, reuse_nxt;
  logic fz_r, fz_nxt, fd_r, fd_nxt, ff_r, ff_nxt, reuse_cfg_r, reuse_cfg_nxt;
  logic has_old_r, has_old_nxt, ni_ok_r, ni_ok_nxt;

  // Payload registers.
  in_req_t  req_r, req_nxt;
  out_rsp_t rslt_r, rslt_nxt, push_data;
  row_t     ins_row_r, ins_row_nxt;
  logic [15:0] find_id_r, find_id_nxt, cur_old_r, cur_old_nxt;

  logic push, out_rdy, in_acc;
  logic i_end, s_end, cnt_full, st_bad, reuse_now, kd, dr;
  logic [19:0] tsum_add;
  logic [13:0] lhs;
  logic [12:0] min_pr;
  logic [SAW-1:0] ro_slot;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign i_end     = (i_r >= cnt_r);
  assign s_end     = (32'(s_r) >= 32'(slot_total_r));
  assign cnt_full  = (32'(cnt_r) >= MEMBERS);
  assign st_bad    = (slot_total_r == 13'd0) || (32'(slot_total_r) > SLOTS);
  assign reuse_now = reuse_cfg_r && (32'(olo_r) == 32'(slot_total_r));
  assign tsum_add  = {1'b0, tsum_r} + 20'(in_data.target_count);
  assign min_pr    = (mm_rdata.pend < mm_rdata.rem) ? mm_rdata.pend : mm_rdata.rem;
  assign kd        = has_old_r && (i_r == pos_r);
  assign dr        = drop_remaining(mm_rdata.pend, mm_rdata.rem);
  assign lhs       = 14'(kept_r) + 14'(kd) + 14'(ach_r) - 14'(dr);
  assign ro_slot   = (32'(rptr_r) >= 32'(slot_total_r)) ? '0 : rptr_r;

  always_comb begin
    push_data            = rslt_r;
    push_data.churn      = move_r;
    push_data.kept_slots = kept_r;
  end

  always_comb begin
    state_nxt = state_r;     ret_nxt = ret_r;       i_nxt = i_r;       n_nxt = n_r;
    pos_nxt = pos_r;         cnt_nxt = cnt_r;       s_nxt = s_r;       olo_nxt = olo_r;
    rptr_nxt = rptr_r;       tsum_nxt = tsum_r;     budget_nxt = budget_r;
    ach_nxt = ach_r;         kept_nxt = kept_r;     move_nxt = move_r;
    slot_total_nxt = slot_total_r;                  limit_nxt = limit_r;
    rstat_nxt = rstat_r;     hit_nxt = hit_r;       donors_nxt = donors_r;
    reused_nxt = reused_r;   reuse_nxt = reuse_r;   fz_nxt = fz_r;     fd_nxt = fd_r;
    ff_nxt = ff_r;           reuse_cfg_nxt = reuse_cfg_r;
    has_old_nxt = has_old_r; ni_ok_nxt = ni_ok_r;
    req_nxt = req_r;         rslt_nxt = rslt_r;     ins_row_nxt = ins_row_r;
    find_id_nxt = find_id_r; cur_old_nxt = cur_old_r;
    mm_we = 1'b0;  mm_waddr = i_r[MIW-1:0];  mm_wdata = mm_rdata;  mm_raddr = i_r[MIW-1:0];
    sm_we = 1'b0;  sm_waddr = s_r[SAW-1:0];  sm_wdata = sm_rdata;  sm_raddr = s_r[SAW-1:0];
    push = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_data;
          rslt_nxt = '0;
          rslt_nxt.status = rstat_r;
          state_nxt = S_RESP;
          case (cmd_e'(in_data.command))
            CMD_CLEAR: begin
              cnt_nxt = '0;     olo_nxt = '0;    tsum_nxt = '0;   budget_nxt = '0;
              ach_nxt = '0;     kept_nxt = '0;   move_nxt = '0;   rptr_nxt = '0;
              fz_nxt = 1'b0;    fd_nxt = 1'b0;   ff_nxt = 1'b0;   reused_nxt = 1'b0;
              donors_nxt = 1'b0;
              rstat_nxt = STS_NOTREADY;
              rslt_nxt.status = STS_OK;
            end
            CMD_TARGET: begin
              tsum_nxt  = (tsum_add > 20'(SUM_MAX)) ? SUM_MAX : tsum_add[18:0];
              rstat_nxt = STS_NOTREADY;
              i_nxt = '0;
              n_nxt = '0;
              ret_nxt   = S_TL_STRIP;
              state_nxt = donors_r ? S_STR_RD : S_TL_STRIP;
            end
            CMD_OWNER: begin
              rstat_nxt = STS_NOTREADY;
              if (32'(olo_r) < SLOTS) begin
                sm_we    = 1'b1;
                sm_waddr = olo_r[SAW-1:0];
                sm_wdata = '{old: in_data.member_id, nidx: '0};
                olo_nxt  = olo_r + 1'b1;
                rslt_nxt.status = STS_OK;
              end else begin
                rslt_nxt.status = STS_FULL;
              end
            end
            CMD_RUN: begin
              rptr_nxt = '0;
              i_nxt = '0;
              n_nxt = '0;
              ret_nxt   = S_RUN_CHK;
              state_nxt = donors_r ? S_STR_RD : S_RUN_CHK;
            end
            CMD_READ: begin
              if (rstat_r == STS_OK) begin
                state_nxt = S_RO_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_rdy) begin
          push = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_STR_RD: begin
        if (i_end) begin
          cnt_nxt = n_r;
          donors_nxt = 1'b0;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_STR_EX;
        end
      end
      S_STR_EX: begin
        if (mm_rdata.is_tgt) begin
          mm_we = 1'b1;
          mm_waddr = n_r[MIW-1:0];
          n_nxt = n_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_STR_RD;
      end

      S_FND_RD: begin
        if (i_end) begin
          pos_nxt = i_r;
          hit_nxt = 1'b0;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_FND_EX;
        end
      end
      S_FND_EX: begin
        if (mm_rdata.id < find_id_r) begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_FND_RD;
        end else begin
          pos_nxt = i_r;
          hit_nxt = (mm_rdata.id == find_id_r);
          state_nxt = ret_r;
        end
      end

      S_INS_RD: begin
        if (i_r == pos_r) begin
          mm_we = 1'b1;
          mm_waddr = pos_r[MIW-1:0];
          mm_wdata = ins_row_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ret_r;
        end else begin
          mm_raddr = MIW'(i_r - 1'b1);
          state_nxt = S_INS_EX;
        end
      end
      S_INS_EX: begin
        mm_we = 1'b1;
        i_nxt = i_r - 1'b1;
        state_nxt = S_INS_RD;
      end

      S_TL_STRIP: begin
        if (req_r.member_id == 16'd0) begin
          fz_nxt = 1'b1;
          rslt_nxt.status = STS_ZERO;
          state_nxt = S_RESP;
        end else begin
          find_id_nxt = req_r.member_id;
          i_nxt = '0;
          ret_nxt = S_TL_FOUND;
          state_nxt = S_FND_RD;
        end
      end
      S_TL_FOUND: begin
        if (hit_r) begin
          fd_nxt = 1'b1;
          rslt_nxt.status = STS_DUP;
          state_nxt = S_RESP;
        end else if (cnt_full) begin
          ff_nxt = 1'b1;
          rslt_nxt.status = STS_FULL;
          state_nxt = S_RESP;
        end else begin
          ins_row_nxt = '{id: req_r.member_id, tgt: req_r.target_count, is_tgt: 1'b1,
                          rem: 13'd0, pend: 13'd0};
          rslt_nxt.status = STS_OK;
          i_nxt = cnt_r;
          ret_nxt = S_RESP;
          state_nxt = S_INS_RD;
        end
      end

      S_RUN_CHK: begin
        kept_nxt = '0;  move_nxt = '0;  budget_nxt = '0;  ach_nxt = '0;
        reused_nxt = 1'b0;
        state_nxt = S_RESP;
        if (st_bad) begin
          rstat_nxt = STS_INCONS;
        end else if (fz_r) begin
          rstat_nxt = STS_ZERO;
        end else if (fd_r) begin
          rstat_nxt = STS_DUP;
        end else if (ff_r) begin
          rstat_nxt = STS_FULL;
        end else if (tsum_r != {6'd0, slot_total_r}) begin
          rstat_nxt = STS_INCONS;
        end else begin
          reuse_nxt = reuse_now;
          s_nxt = '0;
          state_nxt = reuse_now ? S_DON_RD : S_RUN_CNT;
        end
        rslt_nxt.status = rstat_nxt;
      end
      S_DON_RD: begin
        state_nxt = s_end ? S_RUN_CNT : S_DON_EX;
      end
      S_DON_EX: begin
        if (sm_rdata.old == 16'd0) begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_DON_RD;
        end else begin
          find_id_nxt = sm_rdata.old;
          i_nxt = '0;
          ret_nxt = S_DON_POST;
          state_nxt = S_FND_RD;
        end
      end
      S_DON_POST: begin
        if (hit_r) begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_DON_RD;
        end else if (cnt_full) begin
          rstat_nxt = STS_FULL;
          rslt_nxt.status = STS_FULL;
          state_nxt = S_RESP;
        end else begin
          ins_row_nxt = '{id: find_id_r, tgt: 13'd0, is_tgt: 1'b0, rem: 13'd0, pend: 13'd0};
          donors_nxt = 1'b1;
          s_nxt = s_r + 1'b1;
          i_nxt = cnt_r;
          ret_nxt = S_DON_RD;
          state_nxt = S_INS_RD;
        end
      end
      S_RUN_CNT: begin
        reused_nxt = reuse_r;
        if (cnt_r == '0) begin
          rstat_nxt = STS_INCONS;
          rslt_nxt.status = STS_INCONS;
          state_nxt = S_RESP;
        end else begin
          i_nxt = '0;
          state_nxt = S_INIT_RD;
        end
      end

      S_INIT_RD: begin
        if (i_end) begin
          s_nxt = '0;
          i_nxt = '0;
          state_nxt = reuse_r ? S_PEND_RD : S_BUD_RD;
        end else begin
          state_nxt = S_INIT_EX;
        end
      end
      S_INIT_EX: begin
        mm_we = 1'b1;
        mm_wdata.rem  = mm_rdata.tgt;
        mm_wdata.pend = 13'd0;
        i_nxt = i_r + 1'b1;
        state_nxt = S_INIT_RD;
      end

      S_PEND_RD: begin
        if (s_end) begin
          i_nxt = '0;
          state_nxt = S_BUD_RD;
        end else begin
          state_nxt = S_PEND_EX;
        end
      end
      S_PEND_EX: begin
        if (sm_rdata.old == 16'd0) begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_PEND_RD;
        end else begin
          find_id_nxt = sm_rdata.old;
          i_nxt = '0;
          ret_nxt = S_PEND_ADD;
          state_nxt = S_FND_RD;
        end
      end
      S_PEND_ADD: begin
        mm_raddr = pos_r[MIW-1:0];
        state_nxt = S_PEND_WR;
      end
      S_PEND_WR: begin
        mm_we = 1'b1;
        mm_waddr = pos_r[MIW-1:0];
        mm_wdata.pend = mm_rdata.pend + 1'b1;
        s_nxt = s_r + 1'b1;
        state_nxt = S_PEND_RD;
      end

      S_BUD_RD: begin
        if (i_end) begin
          ach_nxt = budget_r;
          s_nxt = '0;
          state_nxt = S_SL_RD;
        end else begin
          state_nxt = S_BUD_EX;
        end
      end
      S_BUD_EX: begin
        budget_nxt = budget_r + min_pr;
        i_nxt = i_r + 1'b1;
        state_nxt = S_BUD_RD;
      end

      S_SL_RD: begin
        state_nxt = s_end ? S_FIN : S_SL_EX;
      end
      S_SL_EX: begin
        cur_old_nxt = sm_rdata.old;
        has_old_nxt = reuse_r && (sm_rdata.old != 16'd0);
        i_nxt = '0;
        if (reuse_r && (sm_rdata.old != 16'd0)) begin
          find_id_nxt = sm_rdata.old;
          ret_nxt = S_OI_RD;
          state_nxt = S_FND_RD;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_OI_RD: begin
        mm_raddr = pos_r[MIW-1:0];
        state_nxt = S_OI_EX;
      end
      S_OI_EX: begin
        ach_nxt = ach_r - 13'(drop_pending(mm_rdata.pend, mm_rdata.rem));
        mm_we = 1'b1;
        mm_waddr = pos_r[MIW-1:0];
        mm_wdata.pend = mm_rdata.pend - 1'b1;
        i_nxt = '0;
        state_nxt = S_SC_RD;
      end
      S_SC_RD: begin
        if (i_end) begin
          rstat_nxt = STS_INTERNAL;
          rslt_nxt.status = STS_INTERNAL;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SC_EX;
        end
      end
      S_SC_EX: begin
        if ((mm_rdata.rem != 13'd0) && (lhs >= 14'(budget_r))) begin
          ach_nxt = ach_r - 13'(dr);
          mm_we = 1'b1;
          mm_wdata.rem = mm_rdata.rem - 1'b1;
          sm_we = 1'b1;
          sm_wdata = '{old: cur_old_r, nidx: i_r[MIW-1:0]};
          if (kd) begin
            kept_nxt = kept_r + 1'b1;
          end else begin
            move_nxt = move_r + 1'b1;
          end
          s_nxt = s_r + 1'b1;
          state_nxt = S_SL_RD;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_SC_RD;
        end
      end

      S_FIN: begin
        if (kept_r != budget_r) begin
          rstat_nxt = STS_INTERNAL;
          rslt_nxt.status = STS_INTERNAL;
          state_nxt = S_RESP;
        end else begin
          i_nxt = '0;
          state_nxt = S_FC_RD;
        end
      end
      S_FC_RD: begin
        if (i_end) begin
          rstat_nxt = (move_r > limit_r) ? STS_MOVES : STS_OK;
          rslt_nxt.status = rstat_nxt;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FC_EX;
        end
      end
      S_FC_EX: begin
        if (mm_rdata.rem != 13'd0) begin
          rstat_nxt = STS_INTERNAL;
          rslt_nxt.status = STS_INTERNAL;
          state_nxt = S_RESP;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_FC_RD;
        end
      end

      S_RO_RD: begin
        sm_raddr = ro_slot;
        s_nxt = SCW'(ro_slot);
        state_nxt = S_RO_EX;
      end
      S_RO_EX: begin
        rslt_nxt.old_owner = reused_r ? sm_rdata.old : 16'd0;
        ni_ok_nxt = (MCW'(sm_rdata.nidx) < cnt_r);
        mm_raddr = sm_rdata.nidx;
        state_nxt = S_RO_EX2;
      end
      S_RO_EX2: begin
        rslt_nxt.status     = STS_OK;
        rslt_nxt.slot_index = 12'(s_r);
        rslt_nxt.new_owner  = ni_ok_r ? mm_rdata.id : 16'd0;
        rslt_nxt.moved      = (rslt_nxt.new_owner != rslt_r.old_owner);
        rslt_nxt.last       = (32'(s_r) + 1 == 32'(slot_total_r));
        rptr_nxt = rslt_nxt.last ? '0 : SAW'(s_r + 1'b1);
        state_nxt = S_RESP;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_TOTAL: begin
          slot_total_nxt = cfg_data;
          rstat_nxt = STS_NOTREADY;
        end
        CFG_MOVE_LIMIT: begin
          limit_nxt = cfg_data;
          rstat_nxt = STS_NOTREADY;
        end
        CFG_REUSE: begin
          reuse_cfg_nxt = cfg_data[0];
          rstat_nxt = STS_NOTREADY;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;      ret_r <= S_IDLE;
      i_r <= '0;  n_r <= '0;  pos_r <= '0;  cnt_r <= '0;  s_r <= '0;  olo_r <= '0;
      rptr_r <= '0;  tsum_r <= '0;  budget_r <= '0;  ach_r <= '0;  kept_r <= '0;
      move_r <= '0;
      slot_total_r <= 13'd4096;  limit_r <= 13'd4096;  reuse_cfg_r <= 1'b0;
      rstat_r <= STS_NOTREADY;
      hit_r <= 1'b0;  donors_r <= 1'b0;  reused_r <= 1'b0;  reuse_r <= 1'b0;
      fz_r <= 1'b0;   fd_r <= 1'b0;      ff_r <= 1'b0;
      has_old_r <= 1'b0;  ni_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;   ret_r <= ret_nxt;
      i_r <= i_nxt;  n_r <= n_nxt;  pos_r <= pos_nxt;  cnt_r <= cnt_nxt;  s_r <= s_nxt;
      olo_r <= olo_nxt;  rptr_r <= rptr_nxt;  tsum_r <= tsum_nxt;  budget_r <= budget_nxt;
      ach_r <= ach_nxt;  kept_r <= kept_nxt;  move_r <= move_nxt;
      slot_total_r <= slot_total_nxt;  limit_r <= limit_nxt;  reuse_cfg_r <= reuse_cfg_nxt;
      rstat_r <= rstat_nxt;
      hit_r <= hit_nxt;  donors_r <= donors_nxt;  reused_r <= reused_nxt;
      reuse_r <= reuse_nxt;
      fz_r <= fz_nxt;    fd_r <= fd_nxt;          ff_r <= ff_nxt;
      has_old_r <= has_old_nxt;  ni_ok_r <= ni_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rslt_r    <= rslt_nxt;
    ins_row_r <= ins_row_nxt;
    find_id_r <= find_id_nxt;
    cur_old_r <= cur_old_nxt;
  end

  mcsr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .ready     (out_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/mcsr_checker.sv]
// Port-level assertions for the slot rebalancer and the bind that attaches them.
module mcsr_checker #(
  parameter int SLOTS = mcsr_pkg::SLOTS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input mcsr_pkg::out_rsp_t out_data
);
  import mcsr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STS_OK) |->
      (out_data.slot_index == 12'd0) && (out_data.new_owner == 16'd0) &&
      (out_data.old_owner == 16'd0) && !out_data.moved && !out_data.last)
    else $error("failed response carries slot data");

  a_moved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.moved == (out_data.new_owner != out_data.old_owner))
    else $error("moved flag disagrees with owners");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.churn) + 32'(out_data.kept_slots)) <= SLOTS)
    else $error("kept plus moved slots exceed the slot space");

endmodule

bind min_churn_slot_rebalancer_core mcsr_checker #(.SLOTS(SLOTS)) u_mcsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
